// ===== src/ekset_pkg.sv =====
// ----------------------------------------------------------------------------
// ekset_pkg
// Shared constants and types of the expiring key set: sizes, action and
// status codes, the stored entry layout and the result beat layout.
// ----------------------------------------------------------------------------
`default_nettype none

package ekset_pkg;

  localparam int unsigned ENTRIES     = 32;
  localparam int unsigned KEY_BITS    = 32;
  localparam int unsigned MAX_RESULTS = 32;

  localparam int unsigned KEY_W     = 32;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned TIMEOUT_W = 16;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd60;

  localparam int unsigned ADDR_BITS = $clog2(ENTRIES);
  localparam int unsigned ORD_BITS  = $clog2(ENTRIES);
  localparam int unsigned CNT_BITS  = $clog2(ENTRIES + 1);
  localparam int unsigned NRES_BITS = $clog2(MAX_RESULTS + 1);

  typedef logic [ADDR_BITS-1:0] addr_t;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_TOUCH  = 2'd1,
    ACT_DELETE = 2'd2,
    ACT_SCAN   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EXISTS    = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [TIME_W-1:0]   stamp;
    logic [ORD_BITS-1:0] ord;
  } entry_t;

  typedef struct packed {
    status_e            status;
    logic               exp_valid;
    logic [KEY_W-1:0]   exp_key;
    logic               last;
  } result_t;

endpackage

`default_nettype wire

// ===== src/ekset_ram.sv =====
// ----------------------------------------------------------------------------
// ekset_ram
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ekset_ram #(
  parameter  int unsigned WIDTH = 8,
  parameter  int unsigned DEPTH = 32,
  localparam int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== src/ekset_ctrl.sv =====
// ----------------------------------------------------------------------------
// ekset_ctrl
// Operation sequencer of the expiring key set. Holds the entry memory and
// the valid bits, sweeps the memory to search and to close rank gaps, and
// hands one result beat at a time to the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ekset_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [1:0]                action_i,
  input  logic [31:0]               key_i,
  input  logic [31:0]               now_i,
  input  logic [15:0]               timeout_i,
  input  logic                      out_free_i,
  output logic                      emit_o,
  output ekset_pkg::result_t        res_o
);

  import ekset_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SRCH   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_GAP    = 3'd3;
  localparam logic [2:0] S_EMITP  = 3'd4;
  localparam logic [2:0] S_EMIT   = 3'd5;

  localparam int unsigned SWEEP_BITS = $clog2(ENTRIES + 1);
  localparam int unsigned ENTRY_W    = $bits(entry_t);

  localparam logic [SWEEP_BITS-1:0] SWEEP_END = SWEEP_BITS'(ENTRIES);
  localparam logic [CNT_BITS-1:0]   CNT_FULL  = CNT_BITS'(ENTRIES);
  localparam logic [NRES_BITS-1:0]  NRES_MAX  = NRES_BITS'(MAX_RESULTS);

  logic [2:0]            state_q, state_d;
  action_e               op_q, op_d;
  logic [KEY_BITS-1:0]   key_q, key_d;
  logic [TIME_W-1:0]     now_q, now_d;
  logic [SWEEP_BITS-1:0] cyc_q, cyc_d;
  addr_t                 rd_idx_q, rd_idx_d;
  logic                  found_q, found_d;
  addr_t                 fidx_q, fidx_d;
  logic [ORD_BITS-1:0]   ford_q, ford_d;
  logic [TIME_W-1:0]     fstamp_q, fstamp_d;
  logic [KEY_BITS-1:0]   fkey_q, fkey_d;
  logic [ENTRIES-1:0]    valid_q, valid_d;
  logic [CNT_BITS-1:0]   cnt_q, cnt_d;
  logic [NRES_BITS-1:0]  nres_q, nres_d;
  logic                  pend_q, pend_d;
  logic [KEY_BITS-1:0]   pkey_q, pkey_d;
  result_t               res_q, res_d;

  logic                  mem_we;
  addr_t                 mem_waddr;
  entry_t                mem_wdata;
  logic                  mem_re;
  addr_t                 mem_raddr;
  logic [ENTRY_W-1:0]    mem_rdata;
  entry_t                rd_entry;
  logic                  rd_valid;
  logic                  match;
  logic                  expire;
  addr_t                 free_idx;

  ekset_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign rd_entry = entry_t'(mem_rdata);
  assign rd_valid = valid_q[rd_idx_q];

  always_comb begin
    if (op_q == ACT_SCAN) begin
      match = rd_valid && (rd_entry.ord == '0);
    end else begin
      match = rd_valid && (rd_entry.key == key_q);
    end
  end

  // time going back counts as young
  assign expire = found_q && (fstamp_q <= now_q) &&
                  ((now_q - fstamp_q) >= TIME_W'(timeout_i));

  // lowest free slot
  always_comb begin
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_idx = ADDR_BITS'(i);
      end
    end
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign res_o      = res_q;

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    key_d     = key_q;
    now_d     = now_q;
    cyc_d     = cyc_q;
    rd_idx_d  = rd_idx_q;
    found_d   = found_q;
    fidx_d    = fidx_q;
    ford_d    = ford_q;
    fstamp_d  = fstamp_q;
    fkey_d    = fkey_q;
    valid_d   = valid_q;
    cnt_d     = cnt_q;
    nres_d    = nres_q;
    pend_d    = pend_q;
    pkey_d    = pkey_q;
    res_d     = res_q;
    mem_we    = 1'b0;
    mem_waddr = rd_idx_q;
    mem_wdata = rd_entry;
    mem_re    = 1'b0;
    mem_raddr = cyc_q[ADDR_BITS-1:0];
    emit_o    = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d    = action_e'(action_i);
          key_d   = KEY_BITS'(key_i);
          now_d   = now_i;
          cyc_d   = '0;
          found_d = 1'b0;
          nres_d  = '0;
          pend_d  = 1'b0;
          state_d = S_SRCH;
        end
      end

      S_SRCH: begin
        mem_re   = (cyc_q != SWEEP_END);
        rd_idx_d = cyc_q[ADDR_BITS-1:0];
        if ((cyc_q != '0) && match && !found_q) begin
          found_d  = 1'b1;
          fidx_d   = rd_idx_q;
          ford_d   = rd_entry.ord;
          fstamp_d = rd_entry.stamp;
          fkey_d   = rd_entry.key;
        end
        if (cyc_q == SWEEP_END) begin
          state_d = S_DECIDE;
        end else begin
          cyc_d = cyc_q + 1'b1;
        end
      end

      S_DECIDE: begin
        case (op_q)
          ACT_ADD: begin
            state_d = S_EMIT;
            if (found_q) begin
              res_d = '{status: ST_EXISTS, exp_valid: 1'b0, exp_key: '0, last: 1'b1};
            end else if (cnt_q == CNT_FULL) begin
              res_d = '{status: ST_FULL, exp_valid: 1'b0, exp_key: '0, last: 1'b1};
            end else begin
              mem_we          = 1'b1;
              mem_waddr       = free_idx;
              mem_wdata.key   = key_q;
              mem_wdata.stamp = now_q;
              mem_wdata.ord   = ORD_BITS'(cnt_q);
              valid_d[free_idx] = 1'b1;
              cnt_d           = cnt_q + 1'b1;
              res_d = '{status: ST_OK, exp_valid: 1'b0, exp_key: '0, last: 1'b1};
            end
          end
          ACT_TOUCH, ACT_DELETE: begin
            if (!found_q) begin
              res_d   = '{status: ST_NOT_FOUND, exp_valid: 1'b0, exp_key: '0, last: 1'b1};
              state_d = S_EMIT;
            end else begin
              cyc_d   = '0;
              state_d = S_GAP;
            end
          end
          ACT_SCAN: begin
            if (expire && (nres_q != NRES_MAX)) begin
              if (pend_q) begin
                res_d   = '{status: ST_OK, exp_valid: 1'b1,
                            exp_key: KEY_W'(pkey_q), last: 1'b0};
                state_d = S_EMITP;
              end else begin
                pkey_d  = fkey_q;
                pend_d  = 1'b1;
                nres_d  = nres_q + 1'b1;
                cyc_d   = '0;
                state_d = S_GAP;
              end
            end else begin
              if (pend_q) begin
                res_d = '{status: ST_OK, exp_valid: 1'b1,
                          exp_key: KEY_W'(pkey_q), last: 1'b1};
              end else begin
                res_d = '{status: ST_OK, exp_valid: 1'b0, exp_key: '0, last: 1'b1};
              end
              state_d = S_EMIT;
            end
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end

      S_GAP: begin
        mem_re   = (cyc_q != SWEEP_END);
        rd_idx_d = cyc_q[ADDR_BITS-1:0];
        if (cyc_q != '0) begin
          if ((op_q == ACT_TOUCH) && (rd_idx_q == fidx_q)) begin
            mem_we          = 1'b1;
            mem_wdata.stamp = now_q;
            mem_wdata.ord   = ORD_BITS'(cnt_q - 1'b1);
          end else if (rd_valid && (rd_entry.ord > ford_q)) begin
            mem_we        = 1'b1;
            mem_wdata.ord = ORD_BITS'(rd_entry.ord - 1'b1);
          end
        end
        if (cyc_q == SWEEP_END) begin
          if (op_q != ACT_TOUCH) begin
            valid_d[fidx_q] = 1'b0;
            cnt_d           = cnt_q - 1'b1;
          end
          if (op_q == ACT_SCAN) begin
            cyc_d   = '0;
            found_d = 1'b0;
            state_d = S_SRCH;
          end else begin
            res_d   = '{status: ST_OK, exp_valid: 1'b0, exp_key: '0, last: 1'b1};
            state_d = S_EMIT;
          end
        end else begin
          cyc_d = cyc_q + 1'b1;
        end
      end

      S_EMITP: begin
        if (out_free_i) begin
          emit_o  = 1'b1;
          pkey_d  = fkey_q;
          nres_d  = nres_q + 1'b1;
          cyc_d   = '0;
          state_d = S_GAP;
        end
      end

      S_EMIT: begin
        if (out_free_i) begin
          emit_o  = 1'b1;
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cyc_q   <= '0;
      found_q <= 1'b0;
      valid_q <= '0;
      cnt_q   <= '0;
      nres_q  <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cyc_q   <= cyc_d;
      found_q <= found_d;
      valid_q <= valid_d;
      cnt_q   <= cnt_d;
      nres_q  <= nres_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    key_q    <= key_d;
    now_q    <= now_d;
    rd_idx_q <= rd_idx_d;
    fidx_q   <= fidx_d;
    ford_q   <= ford_d;
    fstamp_q <= fstamp_d;
    fkey_q   <= fkey_d;
    pkey_q   <= pkey_d;
    res_q    <= res_d;
  end

endmodule

`default_nettype wire

// ===== src/expiring_key_set_core.sv =====
// ----------------------------------------------------------------------------
// expiring_key_set_core
// Bounded set of keys kept in age order, with add, touch, delete and expiry
// scan. Timeout register, output register and operation sequencer.
// ----------------------------------------------------------------------------
// Each operation sweeps the entry memory one read per cycle. An add, a
// touch or delete that misses, and a scan that removes nothing take one
// search sweep; a touch or a delete that finds its key takes one search
// sweep and one rank update sweep. Every removal in a scan is one search
// for the oldest entry and one rank update sweep, and a last search ends
// the scan on a young entry, on no entry or at the result limit. Results
// leave through an output register: a new request is taken once the last
// result is in it, and a result waiting downstream stalls the next request
// only when that request has a result of its own to hand over.
// The valid bits sit in flip-flops that reset clears, so no clearing pass
// follows reset.
// ----------------------------------------------------------------------------
`default_nettype none

module expiring_key_set_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic [31:0] key_i,
  input  logic [31:0] now_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic        expired_valid_o,
  output logic [31:0] expired_key_o,
  output logic        last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  import ekset_pkg::*;

  logic [TIMEOUT_W-1:0] timeout_q;
  logic                 out_valid_q, out_valid_d;
  result_t              out_q;
  logic                 out_free;
  logic                 emit;
  result_t              res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RESET;
    end else if (cfg_valid_i) begin
      timeout_q <= cfg_data_i;
    end
  end

  ekset_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .action_i   (action_i),
    .key_i      (key_i),
    .now_i      (now_i),
    .timeout_i  (timeout_q),
    .out_free_i (out_free),
    .emit_o     (emit),
    .res_o      (res)
  );

  // output beat register
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_q.status;
  assign expired_valid_o = out_q.exp_valid;
  assign expired_key_o   = out_q.exp_key;
  assign last_o          = out_q.last;

endmodule

`default_nettype wire

// ===== src/ekset_checker.sv =====
// ----------------------------------------------------------------------------
// ekset_sva
// Port-level checks of the expiring key set core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ekset_sva (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  status_o,
  input logic        expired_valid_o,
  input logic [31:0] expired_key_o,
  input logic        last_o
);

  import ekset_pkg::*;

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o &&
      $stable({status_o, expired_valid_o, expired_key_o, last_o}))
    else $error("stalled result beat changed");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again straight after a beat");

  a_more_to_come: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> in_stall_o)
    else $error("idle while a scan still owes its final beat");

  a_expired_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && expired_valid_o |-> status_o == ST_OK)
    else $error("expired key carried with a non-ok status");

  a_key_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !expired_valid_o |-> expired_key_o == '0)
    else $error("key shown without an expired entry");

endmodule

bind expiring_key_set_core ekset_sva u_ekset_sva (.*);

`default_nettype wire

// ===== tb/sv/ekset_checker.sv =====
// ----------------------------------------------------------------------------
// ekset_checker
// Watches the request, result and timeout channels of the expiring key set.
// It keeps its own copy of the key store in age order, works out the result
// beats of every accepted request and compares each accepted result beat,
// field by field, with the oldest one still awaited.
// ----------------------------------------------------------------------------
`default_nettype none

module ekset_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  action_i,
  input  logic [31:0] key_i,
  input  logic [31:0] now_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [1:0]  status_i,
  input  logic        expired_valid_i,
  input  logic [31:0] expired_key_i,
  input  logic        last_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [15:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import ekset_pkg::*;

  bit                   slot_used  [ENTRIES];
  logic [KEY_W-1:0]     slot_key   [ENTRIES];
  logic [TIME_W-1:0]    slot_stamp [ENTRIES];
  int                   slot_rank  [ENTRIES];
  int                   live_count;
  logic [TIMEOUT_W-1:0] expiry_limit;
  result_t              awaited_results [$];
  int                   mismatches;

  function automatic int slot_of_key(logic [KEY_W-1:0] k);
    for (int i = 0; i < ENTRIES; i++)
      if (slot_used[i] && slot_key[i] == k) return i;
    return -1;
  endfunction

  function automatic int oldest_slot();
    for (int i = 0; i < ENTRIES; i++)
      if (slot_used[i] && slot_rank[i] == 0) return i;
    return -1;
  endfunction

  function automatic void close_ranks(int r);
    for (int i = 0; i < ENTRIES; i++)
      if (slot_used[i] && slot_rank[i] > r) slot_rank[i]--;
  endfunction

  function automatic void drop_slot(int i);
    slot_used[i] = 1'b0;
    close_ranks(slot_rank[i]);
    live_count--;
  endfunction

  function automatic void apply_key_op(action_e act, logic [KEY_W-1:0] k,
                                       logic [TIME_W-1:0] t);
    int      i;
    int      n;
    result_t r;
    r.status    = ST_OK;
    r.exp_valid = 1'b0;
    r.exp_key   = '0;
    r.last      = 1'b1;
    case (act)
      ACT_ADD: begin
        i = slot_of_key(k);
        if (i >= 0) begin
          r.status = ST_EXISTS;
        end else begin
          i = 0;
          while (i < ENTRIES && slot_used[i]) i++;
          if (i >= ENTRIES) begin
            r.status = ST_FULL;
          end else begin
            slot_used[i]  = 1'b1;
            slot_key[i]   = k;
            slot_stamp[i] = t;
            slot_rank[i]  = live_count;
            live_count++;
          end
        end
        awaited_results.push_back(r);
      end
      ACT_TOUCH: begin
        i = slot_of_key(k);
        if (i < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          close_ranks(slot_rank[i]);
          slot_rank[i]  = live_count - 1;
          slot_stamp[i] = t;
        end
        awaited_results.push_back(r);
      end
      ACT_DELETE: begin
        i = slot_of_key(k);
        if (i < 0) r.status = ST_NOT_FOUND;
        else drop_slot(i);
        awaited_results.push_back(r);
      end
      default: begin
        n = 0;
        while (n < MAX_RESULTS && live_count > 0) begin
          i = oldest_slot();
          if (i < 0) break;
          // an entry stamped in the future counts as young
          if (t < slot_stamp[i] || (t - slot_stamp[i]) < expiry_limit) break;
          r.exp_valid = 1'b1;
          r.exp_key   = slot_key[i];
          r.last      = 1'b0;
          awaited_results.push_back(r);
          drop_slot(i);
          n++;
        end
        if (n == 0) begin
          r.exp_valid = 1'b0;
          r.exp_key   = '0;
          r.last      = 1'b1;
          awaited_results.push_back(r);
        end else begin
          r = awaited_results.pop_back();
          r.last = 1'b1;
          awaited_results.push_back(r);
        end
      end
    endcase
  endfunction

  function automatic void check_beat();
    result_t want;
    if (awaited_results.size() == 0) begin
      $display("%0t: result beat with none awaited: status %0d valid %0d key %h last %0d",
               $time, status_i, expired_valid_i, expired_key_i, last_i);
      mismatches++;
    end else begin
      want = awaited_results.pop_front();
      if (status_i !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, status_i);
        mismatches++;
      end
      if (expired_valid_i !== want.exp_valid) begin
        $display("%0t: expired_valid expected %0d actual %0d",
                 $time, want.exp_valid, expired_valid_i);
        mismatches++;
      end
      if (expired_key_i !== want.exp_key) begin
        $display("%0t: expired_key expected %h actual %h", $time, want.exp_key, expired_key_i);
        mismatches++;
      end
      if (last_i !== want.last) begin
        $display("%0t: last expected %0d actual %0d", $time, want.last, last_i);
        mismatches++;
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      live_count   = 0;
      expiry_limit = TIMEOUT_RESET;
      awaited_results.delete();
      mismatches   = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) check_beat();
      if (cfg_valid_i && cfg_ready_i) expiry_limit = cfg_data_i;
      if (in_valid_i && !in_stall_i) apply_key_op(action_e'(action_i), key_i, now_i);
      fail_count_o <= mismatches;
      pending_o    <= awaited_results.size();
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Regression of expiring_key_set_core. A short directed run covers every
// action, the key and time extremes, time going back and an empty scan; then
// random phases under several timeouts and idle patterns fill the table,
// expire it in bulk and mix touches and deletes on a small key pool.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ekset_pkg::*;

  localparam int KEY_POOL = 40;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  action = ACT_ADD;
  logic [31:0] key = '0;
  logic [31:0] now_sec = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic        expired_valid;
  logic [31:0] expired_key;
  logic        last_flag;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  int          fail_count;
  int          pending;

  logic [31:0] wall_now = 32'd0;
  logic [15:0] cur_timeout = TIMEOUT_RESET;
  logic [31:0] key_pool [KEY_POOL];
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  bit          hold_req = 1'b0;

  expiring_key_set_core DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .action_i       (action),
    .key_i          (key),
    .now_i          (now_sec),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .status_o       (status),
    .expired_valid_o(expired_valid),
    .expired_key_o  (expired_key),
    .last_o         (last_flag),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_data_i     (cfg_data)
  );

  ekset_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .action_i       (action),
    .key_i          (key),
    .now_i          (now_sec),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .status_i       (status),
    .expired_valid_i(expired_valid),
    .expired_key_i  (expired_key),
    .last_i         (last_flag),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_data_i     (cfg_data),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // receiver: random stall, or a long hold-off when requested
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_left = 500;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  task automatic offer(action_e op, logic [31:0] k, logic [31:0] t);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 2 * ENTRIES + 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    action   <= op;
    key      <= k;
    now_sec  <= t;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_timeout(logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid   <= 1'b0;
    cur_timeout = v;
  endtask

  function automatic logic [31:0] later(logic [31:0] t);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 3) return t - $urandom_range(1, 200);
    if (r < 10) return t + cur_timeout + $urandom_range(0, 3);
    return t + $urandom_range(0, cur_timeout / 3 + 1);
  endfunction

  task automatic run_phase(int unsigned items, bit with_fill);
    action_e     op;
    logic [31:0] k;
    int unsigned r;
    for (int unsigned j = 0; j < items; j++) begin
      if (with_fill && j == items / 2) begin
        // overfill with fresh keys, then expire the lot in one scan
        repeat (ENTRIES + 3) offer(ACT_ADD, $urandom(), wall_now);
        wall_now = wall_now + cur_timeout;
        offer(ACT_SCAN, $urandom(), wall_now);
      end
      r  = $urandom_range(99);
      op = (r < 40) ? ACT_ADD : (r < 60) ? ACT_TOUCH : (r < 75) ? ACT_DELETE : ACT_SCAN;
      k  = ($urandom_range(9) == 0) ? $urandom() : key_pool[$urandom_range(KEY_POOL - 1)];
      if ($urandom_range(1) == 1) wall_now = later(wall_now);
      offer(op, k, wall_now);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed beats under the reset timeout
    offer(ACT_SCAN,   32'hFFFF_FFFF, 32'd0);
    offer(ACT_ADD,    32'h0000_0000, 32'd100);
    offer(ACT_ADD,    32'hFFFF_FFFF, 32'd100);
    offer(ACT_ADD,    32'h0000_0000, 32'd101);
    offer(ACT_ADD,    32'h8000_0001, 32'd110);
    offer(ACT_TOUCH,  32'h0000_0000, 32'd130);
    offer(ACT_TOUCH,  32'h1234_5678, 32'd130);
    offer(ACT_DELETE, 32'h5A5A_5A5A, 32'd131);
    offer(ACT_SCAN,   32'h0000_0000, 32'd159);
    offer(ACT_SCAN,   32'h0000_0000, 32'd170);
    offer(ACT_DELETE, 32'h0000_0000, 32'd171);
    offer(ACT_TOUCH,  32'h0000_0000, 32'd171);
    offer(ACT_ADD,    32'hA5A5_A5A5, 32'hFFFF_FF00);
    offer(ACT_SCAN,   32'h0000_0000, 32'h0000_0010);
    offer(ACT_SCAN,   32'h0000_0000, 32'hFFFF_FFFF);
    offer(ACT_DELETE, 32'hA5A5_A5A5, 32'hFFFF_FFFF);
    wall_now = 32'd200;

    for (int p = 0; p < 6; p++) begin
      wait_drained();
      case (p)
        0: begin write_timeout(16'd60);   send_idle_pct = 0;  stall_pct = 0;  end
        1: begin write_timeout(16'd0);    send_idle_pct = 65; stall_pct = 0;  end
        2: begin write_timeout(16'd1);    send_idle_pct = 0;  stall_pct = 65; end
        3: begin write_timeout(16'hFFFF); send_idle_pct = 26; stall_pct = 26; end
        4: begin write_timeout(16'd17);   send_idle_pct = 0;  stall_pct = 0;  end
        default: begin write_timeout(16'd60); send_idle_pct = 26; stall_pct = 26; end
      endcase
      foreach (key_pool[i]) key_pool[i] = $urandom();
      if (p == 0) hold_req = 1'b1;
      run_phase(48, p == 1 || p == 4);
    end

    wait_drained();
    repeat (2 * ENTRIES + 16) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("expiring_key_set_core regression: pass");
    else
      $display("expiring_key_set_core regression: fail");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("expiring_key_set_core regression: fail");
    $finish;
  end

endmodule

`default_nettype wire

// ===== expiring_key_set_core.f =====
src/ekset_pkg.sv
src/ekset_ram.sv
src/ekset_ctrl.sv
src/expiring_key_set_core.sv
src/ekset_checker.sv
tb/sv/ekset_checker.sv
tb/sv/tb.sv
